// ===== hw/rtl/bxfe_pkg.sv =====
`timescale 1ns / 1ps

package bxfe_pkg;

  localparam int BIN_W   = 32;
  localparam int DIG_N   = 10;
  localparam int DIG_W   = 4 * DIG_N;
  localparam int DD_STEP = 4;
  localparam int DD_ITER = BIN_W / DD_STEP;
  localparam int DD_CW   = $clog2(DD_ITER);
  localparam int GRP_N   = 4;

  localparam logic [1:0] FUNC_HDR   = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_DEC   = 2'd2;
  localparam logic [1:0] FUNC_BLOB  = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TYPE = 2'd1;
  localparam logic [1:0] ERR_WIDE = 2'd2;

  localparam logic [2:0] TYPE_BLOB  = 3'd5;
  localparam logic [2:0] TYPE_UDATA = 3'd6;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [1:0]  err_code;
    logic [2:0]  grp_cnt;
    logic [27:0] groups;
    logic [7:0]  fin_byte;
    logic [3:0]  body_cnt;
    logic        body_dec;
    logic [63:0] body;
  } bxfe_job_t;

endpackage

// ===== hw/rtl/binary_xml_field_encoder.sv =====
`timescale 1ns / 1ps
// Binary-XML field encoder.
// Input stream: one command per transaction. in_tuser carries func (0 header,
// 1 element close, 2 decimal UDATA, 3 BLOB); in_tdata carries type_code and
// the 64-bit value. Output stream: one encoded byte per transaction, tlast on
// the final byte of the command, tuser the error code (nonzero only on a
// single zero byte that replaces the whole run).
// Bytes leave at one per cycle from a registered output stage while out_tready
// is high. A decimal command first runs the BCD converter (double dabble,
// 4 bits per cycle over 32 bits). in_tready is high only between commands;
// the next command may be taken while the last byte still waits in the output
// register.
// When the receiver stalls (out_tready low) the output byte holds and the
// serializer waits; no byte is lost or repeated.
// Reset (rst_n low, synchronous) returns to the idle state and drops
// out_tvalid; no clearing pass is needed.
module binary_xml_field_encoder import bxfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [2:0] type_code, [66:3] value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [1:0] error_code
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             in_acc;
  logic [1:0]       in_func;
  logic [2:0]       in_type;
  logic [63:0]      in_value;
  logic             too_wide;
  logic             bcd_start;
  logic             bcd_done;
  logic [DIG_W-1:0] bcd_digits;
  logic             emit_load;
  logic             emit_busy;
  bxfe_job_t        job;
  bxfe_job_t        cmd_job;
  bxfe_job_t        dec_job;
  logic [2:0]       grp_cnt;
  logic [3:0]       blob_nb;
  logic [3:0]       dig_nb;

  assign in_func  = in_tuser;
  assign in_type  = in_tdata[2:0];
  assign in_value = in_tdata[66:3];
  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign too_wide = (in_value[63:32] != 32'd0);

  always_comb begin
    priority if (in_value[31:25] != 7'd0) grp_cnt = 3'd4;
    else if (in_value[31:18] != 14'd0)    grp_cnt = 3'd3;
    else if (in_value[31:11] != 21'd0)    grp_cnt = 3'd2;
    else if (in_value[31:4] != 28'd0)     grp_cnt = 3'd1;
    else                                  grp_cnt = 3'd0;
  end

  always_comb begin
    blob_nb = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_value[8*i +: 8] != 8'd0) blob_nb = 4'(i + 1);
    end
    dig_nb = 4'd1;
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd_digits[4*i +: 4] != 4'd0) dig_nb = 4'(i + 1);
    end
  end

  always_comb begin
    cmd_job          = '0;
    cmd_job.err_code = ERR_NONE;
    unique case (in_func)
      FUNC_HDR: begin
        if (in_type == 3'd7) begin
          cmd_job.err_code = ERR_TYPE;
        end else if (too_wide) begin
          cmd_job.err_code = ERR_WIDE;
        end else begin
          cmd_job.grp_cnt  = grp_cnt;
          cmd_job.groups   = in_value[31:4];
          cmd_job.fin_byte = {1'b1, in_value[3:0], in_type};
        end
      end
      FUNC_CLOSE: begin
      end
      FUNC_DEC: begin
        cmd_job.err_code = ERR_WIDE;
      end
      FUNC_BLOB: begin
        cmd_job.fin_byte = {1'b1, blob_nb, TYPE_BLOB};
        cmd_job.body_cnt = blob_nb;
        cmd_job.body     = in_value;
      end
      default: begin
      end
    endcase

    dec_job          = '0;
    dec_job.err_code = ERR_NONE;
    dec_job.fin_byte = {1'b1, dig_nb, TYPE_UDATA};
    dec_job.body_cnt = dig_nb;
    dec_job.body_dec = 1'b1;
    dec_job.body     = {{(64 - DIG_W){1'b0}}, bcd_digits};
  end

  always_comb begin
    state_nxt = state_r;
    bcd_start = 1'b0;
    emit_load = 1'b0;
    job       = cmd_job;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_DEC && !too_wide) begin
            bcd_start = 1'b1;
            state_nxt = ST_CONV;
          end else begin
            emit_load = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        job = dec_job;
        if (bcd_done) begin
          emit_load = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  bxfe_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .bin    (in_value[BIN_W-1:0]),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  bxfe_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .job        (job),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_NONE |-> out_tlast && out_tdata == 8'd0)
    else $error("error transaction is not a single zero byte");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !emit_busy)
    else $error("command accepted while serializer busy");

  a_bcd_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_done |-> state_r == ST_CONV)
    else $error("conversion finished outside conversion state");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> !emit_busy)
    else $error("serializer loaded while busy");

endmodule

// ===== hw/rtl/bxfe_bcd.sv =====
`timescale 1ns / 1ps

module bxfe_bcd import bxfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin,
  output logic             done,
  output logic [DIG_W-1:0] digits
);

  logic [BIN_W-1:0] sh_r, sh_nxt;
  logic [DIG_W-1:0] bcd_r, bcd_nxt;
  logic [DD_CW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] b);
    logic [DIG_W-1:0] r;
    r = b;
    for (int k = 0; k < DIG_N; k++) begin
      if (b[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = b[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [BIN_W-1:0] s;
    logic [DIG_W-1:0] d;
    s        = sh_r;
    d        = bcd_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = bin;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int j = 0; j < DD_STEP; j++) begin
        d = add3(d);
        d = {d[DIG_W-2:0], s[BIN_W-1]};
        s = {s[BIN_W-2:0], 1'b0};
      end
      sh_nxt  = s;
      bcd_nxt = d;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DD_CW'(DD_ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

// ===== hw/rtl/bxfe_emit.sv =====
`timescale 1ns / 1ps

module bxfe_emit import bxfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  bxfe_job_t job,
  output logic      busy,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,
  output logic      out_tlast,
  output logic [1:0] out_tuser
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_GRP  = 4'b0010,
    PH_FIN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  phase_t     ph_r, ph_nxt;
  bxfe_job_t  job_r, job_nxt;
  logic [1:0] g_r, g_nxt;
  logic [3:0] b_r, b_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] dat_r, dat_nxt;
  logic       lst_r, lst_nxt;
  logic [1:0] err_r, err_nxt;
  logic       adv;
  logic [6:0] grp_sel;
  logic [7:0] body_sel;
  logic [2:0] g_init;

  assign adv    = !vld_r || out_tready;
  assign g_init = job.grp_cnt - 3'd1;

  always_comb begin
    unique case (g_r)
      2'd0:    grp_sel = job_r.groups[6:0];
      2'd1:    grp_sel = job_r.groups[13:7];
      2'd2:    grp_sel = job_r.groups[20:14];
      default: grp_sel = job_r.groups[27:21];
    endcase
    if (job_r.body_dec) begin
      body_sel = ASCII_ZERO | {4'd0, job_r.body[4*b_r +: 4]};
    end else begin
      body_sel = job_r.body[8*b_r[2:0] +: 8];
    end
  end

  always_comb begin
    ph_nxt  = ph_r;
    job_nxt = job_r;
    g_nxt   = g_r;
    b_nxt   = b_r;
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    lst_nxt = lst_r;
    err_nxt = err_r;
    if (adv) begin
      vld_nxt = 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
        end
        PH_GRP: begin
          vld_nxt = 1'b1;
          dat_nxt = {1'b0, grp_sel};
          lst_nxt = 1'b0;
          err_nxt = ERR_NONE;
          if (g_r == 2'd0) begin
            ph_nxt = PH_FIN;
          end else begin
            g_nxt = g_r - 2'd1;
          end
        end
        PH_FIN: begin
          vld_nxt = 1'b1;
          dat_nxt = job_r.fin_byte;
          err_nxt = job_r.err_code;
          lst_nxt = (job_r.body_cnt == 4'd0);
          b_nxt   = job_r.body_cnt - 4'd1;
          ph_nxt  = (job_r.body_cnt == 4'd0) ? PH_IDLE : PH_BODY;
        end
        PH_BODY: begin
          vld_nxt = 1'b1;
          dat_nxt = body_sel;
          err_nxt = ERR_NONE;
          lst_nxt = (b_r == 4'd0);
          if (b_r == 4'd0) begin
            ph_nxt = PH_IDLE;
          end else begin
            b_nxt = b_r - 4'd1;
          end
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
    if (load) begin
      job_nxt = job;
      g_nxt   = g_init[1:0];
      ph_nxt  = (job.grp_cnt == 3'd0) ? PH_FIN : PH_GRP;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    g_r   <= g_nxt;
    b_r   <= b_nxt;
    dat_r <= dat_nxt;
    lst_r <= lst_nxt;
    err_r <= err_nxt;
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      vld_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign busy       = (ph_r != PH_IDLE);
  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;
  assign out_tlast  = lst_r;
  assign out_tuser  = err_r;

endmodule

// ===== dv/binary_xml_field_encoder_test.sv =====
`timescale 1ns / 1ps

module binary_xml_field_encoder_test import bxfe_pkg::*;;

  localparam int RANDOM_CMDS = 480;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } enc_byte_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  type_code;
    logic [63:0] value;
    logic        lit;
    logic [7:0]  lit_byte;
    logic [1:0]  lit_err;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [2:0] type_code, [66:3] value, rest zero
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;  // [1:0] error_code

  enc_byte_t  expected_bytes [$];
  logic [7:0] encoded_run [$];
  cmd_row_t   directed_rows [$];
  enc_byte_t  head;
  int         mismatches = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;

  binary_xml_field_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void push_result(input logic [7:0] data, input logic last,
                                      input logic [1:0] err);
    enc_byte_t e;
    e.data = data;
    e.last = last;
    e.err  = err;
    expected_bytes.push_back(e);
  endfunction

  // 7-bit groups of v[31:4], most significant first, then the flagged final byte
  function automatic void put_hdr(input logic [2:0] t, input logic [31:0] v);
    logic [27:0] rest;
    logic [6:0]  grp [0:3];
    int          ng;
    rest = v[31:4];
    ng = 0;
    while (rest != 0) begin
      grp[ng] = rest[6:0];
      rest = rest >> 7;
      ng++;
    end
    for (int i = ng - 1; i >= 0; i--) encoded_run.push_back({1'b0, grp[i]});
    encoded_run.push_back({1'b1, v[3:0], t});
  endfunction

  function automatic void encode_command(input logic [1:0] f, input logic [2:0] t,
                                         input logic [63:0] v);
    logic [31:0] num;
    logic [31:0] rem;
    logic [31:0] cnt;
    logic [63:0] mag;
    logic [7:0]  body [$];
    encoded_run.delete();
    case (f)
      FUNC_HDR: begin
        if (t > TYPE_UDATA) begin
          push_result(8'h00, 1'b1, ERR_TYPE);
          return;
        end
        if (v[63:32] != 0) begin
          push_result(8'h00, 1'b1, ERR_WIDE);
          return;
        end
        put_hdr(t, v[31:0]);
      end
      FUNC_CLOSE: encoded_run.push_back(8'h00);
      FUNC_DEC: begin
        if (v[63:32] != 0) begin
          push_result(8'h00, 1'b1, ERR_WIDE);
          return;
        end
        num = v[31:0];
        do begin
          rem = num % 10;
          body.push_front(ASCII_ZERO | rem[7:0]);
          num = num / 10;
        end while (num != 0);
        cnt = body.size();
        put_hdr(TYPE_UDATA, cnt);
        foreach (body[i]) encoded_run.push_back(body[i]);
      end
      default: begin
        mag = v;
        while (mag != 0) begin
          body.push_front(mag[7:0]);
          mag = mag >> 8;
        end
        cnt = body.size();
        put_hdr(TYPE_BLOB, cnt);
        foreach (body[i]) encoded_run.push_back(body[i]);
      end
    endcase
    for (int k = 0; k < encoded_run.size(); k++)
      push_result(encoded_run[k], k == encoded_run.size() - 1, ERR_NONE);
  endfunction

  task automatic add_row(input logic [1:0] f, input logic [2:0] t, input logic [63:0] v,
                         input logic lit, input logic [7:0] lit_byte,
                         input logic [1:0] lit_err);
    cmd_row_t r;
    r.func      = f;
    r.type_code = t;
    r.value     = v;
    r.lit       = lit;
    r.lit_byte  = lit_byte;
    r.lit_err   = lit_err;
    directed_rows.push_back(r);
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_cmd(input cmd_row_t r);
    int gap;
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 72'({$urandom, $urandom, $urandom});
      in_tuser  <= 2'($urandom_range(0, 3));
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {5'b0, r.value, r.type_code};
    do @(posedge clk); while (!in_tready);
    if (r.lit) push_result(r.lit_byte, 1'b1, r.lit_err);
    else encode_command(r.func, r.type_code, r.value);
    @(negedge clk);
  endtask

  initial begin
    cmd_row_t    r;
    int          pick;
    logic [63:0] full;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;

    add_row(FUNC_CLOSE, 3'd0, 64'd0,         1'b1, 8'h00, ERR_NONE);
    add_row(FUNC_CLOSE, 3'd7, {64{1'b1}},    1'b1, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd0, 64'd0,         1'b1, 8'h80, ERR_NONE);
    add_row(FUNC_HDR,   3'd6, 64'd15,        1'b1, 8'hFE, ERR_NONE);
    add_row(FUNC_HDR,   3'd7, 64'd0,         1'b1, 8'h00, ERR_TYPE);
    add_row(FUNC_HDR,   3'd7, {64{1'b1}},    1'b1, 8'h00, ERR_TYPE);
    add_row(FUNC_HDR,   3'd3, 64'h1_0000_0000, 1'b1, 8'h00, ERR_WIDE);
    add_row(FUNC_HDR,   3'd0, 64'hFFFF_FFFF, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd5, 64'd16,        1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd1, 64'h7FF,       1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd2, 64'h800,       1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd4, 64'h0FFF_FFFF, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_HDR,   3'd6, 64'h1000_0000, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_DEC,   3'd0, 64'd0,         1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_DEC,   3'd0, 64'hFFFF_FFFF, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_DEC,   3'd0, 64'h1_0000_0000, 1'b1, 8'h00, ERR_WIDE);
    add_row(FUNC_DEC,   3'd7, {64{1'b1}},    1'b1, 8'h00, ERR_WIDE);
    add_row(FUNC_DEC,   3'd3, 64'd9,         1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_DEC,   3'd0, 64'd10,        1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_DEC,   3'd7, 64'd1000000000, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_BLOB,  3'd7, 64'd0,         1'b1, 8'h85, ERR_NONE);
    add_row(FUNC_BLOB,  3'd0, {64{1'b1}},    1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_BLOB,  3'd2, 64'h8000_0000_0000_0000, 1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_BLOB,  3'd0, 64'd1,         1'b0, 8'h00, ERR_NONE);
    add_row(FUNC_BLOB,  3'd6, 64'h100,       1'b0, 8'h00, ERR_NONE);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_cmd(directed_rows[i]);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r.func      = 2'($urandom_range(0, 3));
      r.type_code = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      r.lit       = 1'b0;
      r.lit_byte  = 8'h00;
      r.lit_err   = ERR_NONE;
      full = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          case ($urandom_range(0, 3))
            0: r.value = 64'd0;
            1: r.value = 64'hFFFF_FFFF;
            2: r.value = 64'h1_0000_0000;
            default: r.value = {64{1'b1}};
          endcase
        end
        1: r.value = full;
        default: begin
          if (r.func == FUNC_BLOB) r.value = full >> $urandom_range(0, 63);
          else r.value = {32'h0, full[31:0]} >> $urandom_range(0, 31);
        end
      endcase
      send_cmd(r);
    end
    in_tvalid <= 1'b0;

    wait (expected_bytes.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[binary_xml_field_encoder] OK");
    end else begin
      $display("[binary_xml_field_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: out_byte %02h last %0b error_code %0d",
               out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        head = expected_bytes.pop_front();
        if (out_tdata !== head.data) begin
          $error("out_byte: expected %02h, actual %02h", head.data, out_tdata);
          mismatches++;
        end
        if (out_tlast !== head.last) begin
          $error("last: expected %0b, actual %0b", head.last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== head.err) begin
          $error("error_code: expected %0d, actual %0d", head.err, out_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[binary_xml_field_encoder] ERROR");
    $finish;
  end

endmodule
